/* hw/rtl/sfeaw_pkg.sv */
// ----------------------------------------------------------------------------
// sfeaw_pkg: shared types and constants of the erase-ahead write sequencer
// Function codes, frame kinds, result codes, phase and queue entry types.
// ----------------------------------------------------------------------------
package sfeaw_pkg;

  // Geometry
  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned PAGE_LG      = 8;
  localparam int unsigned PAGE_BYTES   = 1 << PAGE_LG;
  localparam int unsigned CNT_W        = PAGE_LG + 1;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned FLASH_BYTES  = 8388608;
  localparam int unsigned BASE_W       = 23;
  localparam int unsigned MS_W         = 16;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // Input function codes
  localparam logic [2:0] FN_SESSION = 3'd0;
  localparam logic [2:0] FN_WRITE   = 3'd1;
  localparam logic [2:0] FN_STATUS  = 3'd2;
  localparam logic [2:0] FN_TICK    = 3'd3;
  localparam logic [2:0] FN_LINK    = 3'd4;

  // Frame kinds
  localparam logic [2:0] FK_NONE = 3'd0;
  localparam logic [2:0] FK_RDSR = 3'd1;
  localparam logic [2:0] FK_WREN = 3'd2;
  localparam logic [2:0] FK_SE   = 3'd3;
  localparam logic [2:0] FK_PP   = 3'd4;

  // Result status codes
  localparam logic [2:0] RS_OK    = 3'd0;
  localparam logic [2:0] RS_PROG  = 3'd1;
  localparam logic [2:0] RS_BUSY  = 3'd2;
  localparam logic [2:0] RS_RANGE = 3'd3;
  localparam logic [2:0] RS_IO    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [1:0] CFG_REGION_CAP  = 2'd1;
  localparam logic [1:0] CFG_PROG_TMO    = 2'd2;
  localparam logic [1:0] CFG_ERASE_TMO   = 2'd3;

  // Write phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READY,
    PH_ERASE,
    PH_PROG
  } phase_t;

  // Kind of result group the back end expands
  typedef enum logic [1:0] {
    GK_FINISH,   // one done/error result
    GK_RDSR,     // one read status frame
    GK_ERASE,    // write enable, sector erase, read status
    GK_PROG      // write enable, page program, read status
  } grp_kind_t;

  typedef struct packed {
    grp_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] pos;
    logic [CNT_W-1:0]  cnt;
    logic [2:0]        status;
  } grp_t;

  typedef struct packed {
    logic [BASE_W-1:0] region_base;
    logic [ADDR_W-1:0] region_capacity;
    logic [MS_W-1:0]   program_timeout_ms;
    logic [MS_W-1:0]   erase_timeout_ms;
  } cfg_t;

endpackage

/* hw/rtl/sfeaw_front.sv */
// ----------------------------------------------------------------------------
// sfeaw_front: event classifier and write state keeper
// Takes one event per cycle unless the queue is full, updates session and write
// progress, and pushes at most one result group per event into the queue.
// ----------------------------------------------------------------------------
module sfeaw_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfeaw_pkg::cfg_t              cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_func,
  input  logic [23:0]                  in_session_size,
  input  logic [23:0]                  in_write_offset,
  input  logic [23:0]                  in_write_length,
  input  logic [7:0]                   in_status_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output sfeaw_pkg::grp_t              q_data
);

  localparam int unsigned AW = sfeaw_pkg::ADDR_W;
  localparam int unsigned CW = sfeaw_pkg::CNT_W;
  localparam int unsigned PL = sfeaw_pkg::PAGE_LG;

  sfeaw_pkg::phase_t       phase_r, phase_nxt;
  logic [AW-1:0]           active_r, active_nxt;
  logic [AW-1:0]           mark_r, mark_nxt;
  logic [AW-1:0]           wsa_r, wsa_nxt;
  logic [AW-1:0]           total_r, total_nxt;
  logic [AW-1:0]           progress_r, progress_nxt;
  logic [sfeaw_pkg::MS_W-1:0] elapsed_r, elapsed_nxt;

  logic                    accept;
  logic                    is_idle;
  logic                    size_bad;
  logic                    range_bad;
  logic                    busy_bit;
  logic                    timed_out;
  logic [sfeaw_pkg::MS_W-1:0] limit;
  logic [AW-1:0]           base_ext;
  logic [AW-1:0]           rel;
  logic [AW:0]             rel_end;
  logic [AW:0]             mark_sum;
  logic [AW-1:0]           mark_inc;
  logic [AW-1:0]           mark_use;
  logic                    need_erase;
  logic                    prog_done;
  logic [AW-1:0]           prog_addr;
  logic [CW-1:0]           room;
  logic [AW-1:0]           rem;
  logic [CW-1:0]           chunk;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign is_idle  = (phase_r == sfeaw_pkg::PH_IDLE);

  // Classify the event
  assign size_bad  = (in_session_size == '0) || (in_session_size > cfg.region_capacity);
  assign range_bad = (in_write_offset > active_r) ||
                     (in_write_length > (active_r - in_write_offset));
  assign busy_bit  = in_status_byte[0];
  assign limit     = (phase_r == sfeaw_pkg::PH_ERASE) ? cfg.erase_timeout_ms
                                                      : cfg.program_timeout_ms;
  assign timed_out = (elapsed_r >= limit);

  // Erase-ahead decision; after an erase the mark advances one sector, capped at the session size
  assign base_ext   = {1'b0, cfg.region_base};
  assign rel        = wsa_r - base_ext;
  assign rel_end    = {1'b0, rel} + {1'b0, total_r};
  assign mark_sum   = {1'b0, mark_r} + (AW+1)'(sfeaw_pkg::SECTOR_BYTES);
  assign mark_inc   = (mark_sum > {1'b0, active_r}) ? active_r : mark_sum[AW-1:0];
  assign mark_use   = (phase_r == sfeaw_pkg::PH_ERASE) ? mark_inc : mark_r;
  assign need_erase = (rel_end > {1'b0, mark_use}) && (mark_use < active_r);

  // Next page program cut at the page boundary
  assign prog_done = (progress_r >= total_r);
  assign prog_addr = wsa_r + progress_r;
  assign room      = CW'(sfeaw_pkg::PAGE_BYTES) - {1'b0, prog_addr[PL-1:0]};
  assign rem       = prog_done ? '0 : (total_r - progress_r);
  assign chunk     = (rem < {{(AW-CW){1'b0}}, room}) ? rem[CW-1:0] : room;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (in_func)
        sfeaw_pkg::FN_SESSION: begin
          if (!size_bad) phase_nxt = sfeaw_pkg::PH_IDLE;
        end
        sfeaw_pkg::FN_WRITE: begin
          if (is_idle && !range_bad && (in_write_length != '0)) begin
            phase_nxt = sfeaw_pkg::PH_READY;
          end
        end
        sfeaw_pkg::FN_STATUS: begin
          if (!is_idle) begin
            if (busy_bit) begin
              if (timed_out) phase_nxt = sfeaw_pkg::PH_IDLE;
            end else if (phase_r == sfeaw_pkg::PH_PROG) begin
              phase_nxt = prog_done ? sfeaw_pkg::PH_IDLE : sfeaw_pkg::PH_PROG;
            end else begin
              phase_nxt = need_erase ? sfeaw_pkg::PH_ERASE : sfeaw_pkg::PH_PROG;
            end
          end
        end
        sfeaw_pkg::FN_LINK: begin
          phase_nxt = sfeaw_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  // Datapath updates and result group
  always_comb begin
    active_nxt   = active_r;
    mark_nxt     = mark_r;
    wsa_nxt      = wsa_r;
    total_nxt    = total_r;
    progress_nxt = progress_r;
    elapsed_nxt  = elapsed_r;
    q_push       = 1'b0;
    q_data.kind   = sfeaw_pkg::GK_FINISH;
    q_data.addr   = '0;
    q_data.pos    = '0;
    q_data.cnt    = '0;
    q_data.status = sfeaw_pkg::RS_OK;
    if (accept) begin
      unique case (in_func)
        sfeaw_pkg::FN_SESSION: begin
          q_push = 1'b1;
          if (size_bad) begin
            q_data.status = sfeaw_pkg::RS_RANGE;
          end else begin
            active_nxt = in_session_size;
            mark_nxt   = '0;
          end
        end
        sfeaw_pkg::FN_WRITE: begin
          q_push = 1'b1;
          if (!is_idle) begin
            q_data.status = sfeaw_pkg::RS_BUSY;
          end else if (range_bad) begin
            q_data.status = sfeaw_pkg::RS_RANGE;
          end else if (in_write_length != '0) begin
            wsa_nxt       = base_ext + in_write_offset;
            total_nxt     = in_write_length;
            progress_nxt  = '0;
            elapsed_nxt   = '0;
            q_data.kind   = sfeaw_pkg::GK_RDSR;
            q_data.status = sfeaw_pkg::RS_PROG;
          end
        end
        sfeaw_pkg::FN_STATUS: begin
          if (!is_idle) begin
            q_push = 1'b1;
            if (busy_bit) begin
              if (timed_out) begin
                q_data.status = sfeaw_pkg::RS_IO;
              end else begin
                q_data.kind   = sfeaw_pkg::GK_RDSR;
                q_data.status = sfeaw_pkg::RS_PROG;
              end
            end else if ((phase_r == sfeaw_pkg::PH_PROG) && prog_done) begin
              q_data.status = sfeaw_pkg::RS_OK;
            end else begin
              if (phase_r == sfeaw_pkg::PH_ERASE) mark_nxt = mark_inc;
              elapsed_nxt   = '0;
              q_data.status = sfeaw_pkg::RS_PROG;
              if ((phase_r != sfeaw_pkg::PH_PROG) && need_erase) begin
                q_data.kind = sfeaw_pkg::GK_ERASE;
                q_data.addr = base_ext + mark_use;
              end else begin
                q_data.kind  = sfeaw_pkg::GK_PROG;
                q_data.addr  = prog_addr;
                q_data.pos   = progress_r;
                q_data.cnt   = chunk;
                progress_nxt = progress_r + {{(AW-CW){1'b0}}, chunk};
              end
            end
          end
        end
        sfeaw_pkg::FN_TICK: begin
          if (!is_idle && (elapsed_r != '1)) elapsed_nxt = elapsed_r + 1'b1;
        end
        sfeaw_pkg::FN_LINK: begin
          if (!is_idle) begin
            q_push        = 1'b1;
            q_data.status = sfeaw_pkg::RS_IO;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sfeaw_pkg::PH_IDLE;
      active_r   <= '0;
      mark_r     <= '0;
      wsa_r      <= '0;
      total_r    <= '0;
      progress_r <= '0;
      elapsed_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      active_r   <= active_nxt;
      mark_r     <= mark_nxt;
      wsa_r      <= wsa_nxt;
      total_r    <= total_nxt;
      progress_r <= progress_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

endmodule

/* hw/rtl/sfeaw_queue.sv */
// ----------------------------------------------------------------------------
// sfeaw_queue: small result group queue
// Register FIFO that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module sfeaw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfeaw_pkg::grp_t   push_data,
  input  logic              pop,
  output sfeaw_pkg::grp_t   head,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PW = sfeaw_pkg::Q_PTR_W;

  sfeaw_pkg::grp_t mem_r [sfeaw_pkg::Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;

  assign full  = (count_r == (PW+1)'(sfeaw_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/sfeaw_back.sv */
// ----------------------------------------------------------------------------
// sfeaw_back: result group expander
// Turns each queued group into one to three result items, one per cycle while
// out_stall is low, through an output register.
// ----------------------------------------------------------------------------
module sfeaw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sfeaw_pkg::grp_t   head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_frame_kind,
  output logic [23:0]       out_flash_address,
  output logic [23:0]       out_buffer_position,
  output logic [8:0]        out_byte_count,
  output logic [2:0]        out_result_status,
  output logic              out_last
);

  logic [1:0]  sub_r;
  logic        load;
  logic [2:0]  fr_kind;
  logic [23:0] fr_addr;
  logic [23:0] fr_pos;
  logic [8:0]  fr_cnt;
  logic [2:0]  fr_status;
  logic        fr_last;

  logic        valid_r;
  logic [2:0]  kind_r;
  logic [23:0] addr_r;
  logic [23:0] pos_r;
  logic [8:0]  cnt_r;
  logic [2:0]  status_r;
  logic        last_r;

  assign load  = !q_empty && (!valid_r || !out_stall);
  assign q_pop = load && fr_last;

  // Build the frame for the current step of the head group
  always_comb begin
    fr_kind   = sfeaw_pkg::FK_NONE;
    fr_addr   = '0;
    fr_pos    = '0;
    fr_cnt    = '0;
    fr_status = sfeaw_pkg::RS_PROG;
    fr_last   = 1'b1;
    unique case (head.kind)
      sfeaw_pkg::GK_FINISH: begin
        fr_status = head.status;
      end
      sfeaw_pkg::GK_RDSR: begin
        fr_kind = sfeaw_pkg::FK_RDSR;
      end
      sfeaw_pkg::GK_ERASE, sfeaw_pkg::GK_PROG: begin
        case (sub_r)
          2'd0: begin
            fr_kind = sfeaw_pkg::FK_WREN;
            fr_last = 1'b0;
          end
          2'd1: begin
            fr_last = 1'b0;
            fr_addr = head.addr;
            if (head.kind == sfeaw_pkg::GK_PROG) begin
              fr_kind = sfeaw_pkg::FK_PP;
              fr_pos  = head.pos;
              fr_cnt  = head.cnt;
            end else begin
              fr_kind = sfeaw_pkg::FK_SE;
            end
          end
          default: begin
            fr_kind = sfeaw_pkg::FK_RDSR;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Step through the group and hold the output while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        sub_r   <= fr_last ? 2'd0 : (sub_r + 2'd1);
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= fr_kind;
      addr_r   <= fr_addr;
      pos_r    <= fr_pos;
      cnt_r    <= fr_cnt;
      status_r <= fr_status;
      last_r   <= fr_last;
    end
  end

  assign out_valid           = valid_r;
  assign out_frame_kind      = kind_r;
  assign out_flash_address   = addr_r;
  assign out_buffer_position = pos_r;
  assign out_byte_count      = cnt_r;
  assign out_result_status   = status_r;
  assign out_last            = last_r;

endmodule

/* hw/rtl/spi_flash_erase_ahead_write_sequencer.sv */
// ----------------------------------------------------------------------------
// spi_flash_erase_ahead_write_sequencer: SPI NOR image write sequencer
// Turns session, write, status, tick and link events into command frames
// with sector erase ahead of data and page-bounded page programs.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    func, session size, offset,
//                                              length, status byte
//   out      output     out_valid / out_stall  frame kind, address, buffer
//                                              position, byte count, status,
//                                              last
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// The front end takes one event per cycle while the queue is not full and
// pushes at most one result group into a four-entry queue; the back end emits
// one result item per cycle while out_stall is low, so an event yields zero to
// three items (three for erase or program), via the queue and output register.
// Reset is synchronous; it clears the phase, the session and the queue.
// in_stall rises only when the queue is full; out_stall holds the output
// register and backs up the queue.
// ----------------------------------------------------------------------------
module spi_flash_erase_ahead_write_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [23:0] in_session_size,
  input  logic [23:0] in_write_offset,
  input  logic [23:0] in_write_length,
  input  logic [7:0]  in_status_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_frame_kind,
  output logic [23:0] out_flash_address,
  output logic [23:0] out_buffer_position,
  output logic [8:0]  out_byte_count,
  output logic [2:0]  out_result_status,
  output logic        out_last
);

  sfeaw_pkg::cfg_t cfg_r;
  sfeaw_pkg::grp_t q_in;
  sfeaw_pkg::grp_t q_head;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_base        <= '0;
      cfg_r.region_capacity    <= 24'(sfeaw_pkg::FLASH_BYTES);
      cfg_r.program_timeout_ms <= 16'd100;
      cfg_r.erase_timeout_ms   <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfeaw_pkg::CFG_REGION_BASE: cfg_r.region_base        <= cfg_data[22:0];
        sfeaw_pkg::CFG_REGION_CAP:  cfg_r.region_capacity    <= cfg_data;
        sfeaw_pkg::CFG_PROG_TMO:    cfg_r.program_timeout_ms <= cfg_data[15:0];
        sfeaw_pkg::CFG_ERASE_TMO:   cfg_r.erase_timeout_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sfeaw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_session_size (in_session_size),
    .in_write_offset (in_write_offset),
    .in_write_length (in_write_length),
    .in_status_byte  (in_status_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  sfeaw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  sfeaw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_kind      (out_frame_kind),
    .out_flash_address   (out_flash_address),
    .out_buffer_position (out_buffer_position),
    .out_byte_count      (out_byte_count),
    .out_result_status   (out_result_status),
    .out_last            (out_last)
  );

endmodule
